// ----- sv/sssd_pkg.sv -----
`timescale 1ns / 1ps
package sssd_pkg;

  // Number of scanned positions; the store always holds four.
  localparam int unsigned DIGITS      = 4;
  localparam int unsigned STORE_DEPTH = 4;
  localparam int unsigned POS_W       = 2;
  localparam int unsigned REM_W       = 14;
  localparam int unsigned QUO_W       = 10;
  localparam int unsigned PROD_W      = 27;

  localparam int unsigned SCAN_LEN = (DIGITS < 1) ? 1 :
                                     (DIGITS > STORE_DEPTH) ? STORE_DEPTH : DIGITS;

  localparam logic [31:0]       NUMBER_MAX = 32'd9999;
  // floor(x * 6554 / 2^16) equals floor(x / 10) for x up to 9999
  localparam logic [PROD_W-1:0] RECIP_TEN  = PROD_W'(6554);
  localparam int unsigned       RECIP_SHIFT = 16;
  localparam logic [3:0]        MASK_RESET = 4'b0001;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_DOTS   = 2'd1,
    KIND_SCAN   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] digit_index;
    logic [3:0] digit_enable_n;
    logic [7:0] segments;
  } out_item_t;

  typedef struct packed {
    logic             load_number;
    logic             load_mask;
    logic             scan;
    logic             split_step;
    logic [POS_W-1:0] step_idx;
  } cmd_t;

  function automatic logic [7:0] sssd_encode(input logic [3:0] digit, input logic point);
    logic [6:0] pat;
    begin
      case (digit)
        4'd0:    pat = 7'h3f;
        4'd1:    pat = 7'h06;
        4'd2:    pat = 7'h5b;
        4'd3:    pat = 7'h4f;
        4'd4:    pat = 7'h66;
        4'd5:    pat = 7'h6d;
        4'd6:    pat = 7'h7d;
        4'd7:    pat = 7'h07;
        4'd8:    pat = 7'h7f;
        4'd9:    pat = 7'h6f;
        default: pat = 7'h00;
      endcase
      sssd_encode = {point, pat};
    end
  endfunction

endpackage

// ----- sv/seven_segment_scan_display_top.sv -----
`timescale 1ns / 1ps
// Four-digit multiplexed seven-segment driver.
// Input channel (in_valid_i / in_stall_o / in_item_i) carries items of three
// kinds: a number write (clamped to 9999, shown as four decimal digits, most
// significant on the left), a dot mask write (low four bits, bit i lights the
// point of digit i) and a scan tick. Only a scan tick yields an output item
// on out_valid_o / out_stall_i / out_item_o: the digit index, the active-low
// one-hot digit enable and the segment byte (a..g in bits 0..6, point bit 7).
// Timing: a scan tick or a dot write needs no split steps; a scan result appears
// in the output register in the cycle after acceptance. A number write is
// accepted, then split in four steps of the shared divide-by-ten unit, one
// digit per step, while the input channel stalls.
// Reset clears the display to blank, all digits to zero, the scan position to
// the leftmost digit and the dot mask to 0001; the mask only shows after the
// next write re-encodes the digits.
// While the receiver stalls, the result item holds and new input is stalled
// until the result is taken.
module seven_segment_scan_display_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sssd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sssd_pkg::out_item_t out_item_o
);
  import sssd_pkg::*;

  cmd_t cmd;

  // Sequence the digit split and own the handshakes.
  sssd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_item_i.kind),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Hold digit, segment and mask stores, scan position and result register.
  sssd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .out_item_o (out_item_o)
  );

`ifndef NO_ASSERTIONS
  // A scan tick always leaves a result in the output register.
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan |=> out_valid_o)
    else $error("scan tick produced no result");

  // A number write starts the split at the least significant step.
  a_split_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_number |=> (cmd.split_step && cmd.step_idx == '0))
    else $error("digit split did not start");

  // No input is taken while digits are being split.
  a_split_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.split_step |-> (in_stall_o && !cmd.load_number && !cmd.scan && !cmd.load_mask))
    else $error("input accepted during digit split");

  // The enable drives exactly the indexed digit low.
  a_enable_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(out_item_o.digit_enable_n) == 3 &&
                     out_item_o.digit_enable_n[out_item_o.digit_index] == 1'b0))
    else $error("digit enable does not match digit index");
`endif

endmodule

// ----- sv/sssd_ctrl.sv -----
`timescale 1ns / 1ps
module sssd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_kind_i,
  input  logic          out_stall_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output sssd_pkg::cmd_t cmd_o
);
  import sssd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SPLIT
  } state_e;

  state_e           state_q, state_d;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  // Hold input while splitting or while the result register is stuck.
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.split_step  = (state_q == ST_SPLIT);
    cmd_o.step_idx    = cnt_q;
    if (accept) begin
      unique case (in_kind_i)
        KIND_NUMBER: cmd_o.load_number = 1'b1;
        KIND_DOTS:   cmd_o.load_mask   = 1'b1;
        KIND_SCAN:   cmd_o.scan        = 1'b1;
        default:     ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.scan) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load_number) begin
          state_d = ST_SPLIT;
          cnt_d   = '0;
        end
      end
      ST_SPLIT: begin
        cnt_d = cnt_q + POS_W'(1);
        if (cnt_q == POS_W'(STORE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/sssd_datapath.sv -----
`timescale 1ns / 1ps
module sssd_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sssd_pkg::in_item_t in_item_i,
  input  sssd_pkg::cmd_t     cmd_i,
  output sssd_pkg::out_item_t out_item_o
);
  import sssd_pkg::*;

  logic [REM_W-1:0]  rem_q;
  logic [3:0]        digit_q [STORE_DEPTH];
  logic [7:0]        seg_q   [STORE_DEPTH];
  logic [3:0]        mask_q;
  logic [POS_W-1:0]  pos_q;
  out_item_t         out_q;

  logic [REM_W-1:0]  clamped;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic [REM_W-1:0]  quo_x10;
  logic [REM_W-1:0]  diff;
  logic [3:0]        digit;
  logic [POS_W-1:0]  step_pos;
  logic [POS_W-1:0]  pos_next;

  assign clamped = (in_item_i.value > NUMBER_MAX) ? REM_W'(NUMBER_MAX)
                                                  : in_item_i.value[REM_W-1:0];

  // One decimal digit per step, least significant first, by reciprocal multiply.
  assign prod     = PROD_W'(rem_q) * RECIP_TEN;
  assign quo      = prod[RECIP_SHIFT +: QUO_W];
  assign quo_x10  = REM_W'({quo, 3'b000}) + REM_W'({quo, 1'b0});
  assign diff     = rem_q - quo_x10;
  assign digit    = diff[3:0];
  assign step_pos = POS_W'(STORE_DEPTH - 1) - cmd_i.step_idx;

  assign pos_next = (pos_q == POS_W'(SCAN_LEN - 1)) ? '0 : pos_q + POS_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_number) begin
      rem_q <= clamped;
    end else if (cmd_i.split_step) begin
      rem_q <= REM_W'(quo);
    end
    if (cmd_i.scan) begin
      out_q.digit_index    <= pos_q;
      out_q.digit_enable_n <= ~(4'b0001 << pos_q);
      out_q.segments       <= seg_q[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        digit_q[i] <= '0;
        seg_q[i]   <= '0;
      end
      mask_q <= MASK_RESET;
      pos_q  <= '0;
    end else begin
      if (cmd_i.split_step) begin
        digit_q[step_pos] <= digit;
        seg_q[step_pos]   <= sssd_encode(digit, mask_q[step_pos]);
      end
      if (cmd_i.load_mask) begin
        mask_q <= in_item_i.value[3:0];
        for (int i = 0; i < STORE_DEPTH; i++) begin
          seg_q[i] <= sssd_encode(digit_q[i], in_item_i.value[i]);
        end
      end
      if (cmd_i.scan) begin
        pos_q <= pos_next;
      end
    end
  end

  assign out_item_o = out_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import sssd_pkg::*;

  // Kind 3 is left unused by the block: it must be ignored.
  localparam logic [1:0]  KIND_UNUSED     = 2'd3;
  localparam int unsigned NUM_POS         = 4;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS    = 400;
  localparam logic [31:0] LARGEST_SHOWN   = 32'd9999;
  localparam logic [6:0]  DIGIT_GLYPH [10] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  always #5 clk_i = ~clk_i;

  seven_segment_scan_display_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Display predictor: its own copy of the digit, segment and scan state.
  logic [7:0] shown_seg  [NUM_POS];
  logic [3:0] held_digit [NUM_POS];
  logic [3:0] dot_mask;
  logic [1:0] scan_pos;

  in_item_t    pending_items [$];
  out_item_t   expected_scans [$];
  out_item_t   want_scan;
  int unsigned fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned scans_seen  = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  logic        in_fire     = 1'b0;
  int unsigned cycle_count = 0;

  function automatic void clear_display();
    for (int i = 0; i < NUM_POS; i++) begin
      shown_seg[i]  = '0;
      held_digit[i] = '0;
    end
    dot_mask = 4'b0001;
    scan_pos = '0;
  endfunction

  // Rebuild every segment byte from the held digits and the dot mask.
  function automatic void reencode_digits();
    for (int i = 0; i < NUM_POS; i++)
      shown_seg[i] = {dot_mask[i], DIGIT_GLYPH[held_digit[i]]};
  endfunction

  function automatic void advance_display(input in_item_t item);
    logic [31:0] num;
    out_item_t   scan_out;
    int unsigned span;
    span = (DIGITS < 1) ? 1 : (DIGITS > NUM_POS) ? NUM_POS : DIGITS;
    case (item.kind)
      KIND_NUMBER: begin
        // Clamp, then split into decimal digits, most significant leftmost.
        num = (item.value > LARGEST_SHOWN) ? LARGEST_SHOWN : item.value;
        for (int i = NUM_POS - 1; i >= 0; i--) begin
          held_digit[i] = 4'(num % 10);
          num = num / 10;
        end
        reencode_digits();
      end
      KIND_DOTS: begin
        dot_mask = item.value[3:0];
        reencode_digits();
      end
      KIND_SCAN: begin
        scan_out.digit_index    = scan_pos;
        scan_out.digit_enable_n = ~(4'b0001 << scan_pos);
        scan_out.segments       = shown_seg[scan_pos];
        expected_scans.push_back(scan_out);
        scan_pos = 2'((int'(scan_pos) + 1) % span);
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(input logic [1:0] kind, input logic [31:0] value);
    in_item_t item;
    item.kind  = kind;
    item.value = value;
    pending_items.push_back(item);
  endfunction

  // Run the predictor on every item the block takes.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      advance_display(in_item_i);
      in_fire <= 1'b1;
    end else begin
      in_fire <= 1'b0;
    end
  end

  // Sender: hold a stalled item, otherwise offer the next one or idle.
  // Idling is decided only when no item is pending on the port.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_items.size() != 0 &&
          ((items_sent >= 150 && items_sent < 250) || $urandom_range(99) >= 12)) begin
        in_item_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        items_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the input backs up,
  // and a stretch with no stalls at all.
  always @(negedge clk_i) begin
    if (!hold_done && scans_seen >= 40) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (scans_seen >= 120 && scans_seen < 200) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 12);
    end
  end

  // Compare each scan result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      scans_seen++;
      if (expected_scans.size() == 0) begin
        $error("scan result with no prediction: %h", out_item_o);
        fail_count++;
      end else begin
        want_scan = expected_scans.pop_front();
        if (out_item_o.digit_index !== want_scan.digit_index) begin
          $error("digit_index: expected %0d, actual %0d",
                 want_scan.digit_index, out_item_o.digit_index);
          fail_count++;
        end
        if (out_item_o.digit_enable_n !== want_scan.digit_enable_n) begin
          $error("digit_enable_n: expected %b, actual %b",
                 want_scan.digit_enable_n, out_item_o.digit_enable_n);
          fail_count++;
        end
        if (out_item_o.segments !== want_scan.segments) begin
          $error("segments: expected %h, actual %h",
                 want_scan.segments, out_item_o.segments);
          fail_count++;
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned counted;
    int unsigned pick;
    clear_display();

    // Blank display right after reset, even though the mask reads 0001.
    repeat (4) queue_item(KIND_SCAN, 32'h0);
    queue_item(KIND_NUMBER, 32'd0);
    queue_item(KIND_SCAN, 32'hFFFF_FFFF);
    // Mask bits above bit 3 are ignored.
    queue_item(KIND_DOTS, 32'hFFFF_FFF0);
    // Just past the largest number: clamp to 9999.
    queue_item(KIND_NUMBER, 32'd10000);
    repeat (4) queue_item(KIND_SCAN, 32'h0);
    queue_item(KIND_UNUSED, 32'hFFFF_FFFF);
    queue_item(KIND_NUMBER, 32'hFFFF_FFFF);
    queue_item(KIND_DOTS, 32'h0000_000F);
    queue_item(KIND_NUMBER, 32'd1234);
    repeat (4) queue_item(KIND_SCAN, 32'h0);
    queue_item(KIND_DOTS, 32'h0000_0005);
    queue_item(KIND_NUMBER, LARGEST_SHOWN);
    queue_item(KIND_SCAN, 32'h0);
    queue_item(KIND_NUMBER, 32'd805);
    queue_item(KIND_SCAN, 32'h0);

    // Random part: mostly scan ticks, with writes and some ignored noise.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_item(KIND_SCAN, $urandom());
      end else if (pick < 75) begin
        case ($urandom_range(3))
          0, 1:    queue_item(KIND_NUMBER, $urandom_range(9999));
          2:       queue_item(KIND_NUMBER, $urandom_range(10999, 9990));
          default: queue_item(KIND_NUMBER, $urandom());
        endcase
      end else if (pick < 93) begin
        queue_item(KIND_DOTS, $urandom());
      end else begin
        queue_item(KIND_UNUSED, $urandom());
        counted--;
      end
      counted++;
    end

    // Hold reset, then release it away from the rising edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to go in and every scan result to come out.
    while (pending_items.size() != 0 || in_valid_i || expected_scans.size() != 0)
      @(negedge clk_i);
    // Let a trailing number write finish its digit steps.
    repeat (10) @(posedge clk_i);

    if (expected_scans.size() != 0) begin
      $error("%0d scan results never arrived", expected_scans.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sssd_pkg.sv
sv/sssd_ctrl.sv
sv/sssd_datapath.sv
sv/seven_segment_scan_display_top.sv
verif/testbench.sv
